[hdl/wav_pcm_header_parser_unit_macros.svh]
// Assertion macros shared by the WAV header parser modules.
// Needs only the clock and reset names passed in by the caller.
`ifndef WAV_PCM_HEADER_PARSER_UNIT_MACROS_SVH
`define WAV_PCM_HEADER_PARSER_UNIT_MACROS_SVH

// same-cycle implication
`define WPP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("wpp assertion failed");

// next-cycle implication
`define WPP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("wpp assertion failed");

`endif

[hdl/wpp_pkg.sv]
// Package for the WAV header parser: layout constants, status codes,
// item/result types and the fixed-byte lookup. No dependencies.
package wpp_pkg;

  localparam int HDR_BYTES = 44;
  localparam int POS_W     = $clog2(HDR_BYTES + 1);
  localparam logic [POS_W-1:0] POS_IDLE = POS_W'(HDR_BYTES);

  localparam logic [15:0] BITS_8  = 16'd8;
  localparam logic [15:0] BITS_16 = 16'd16;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_BAD   = 2'd1,
    ST_SIZE  = 2'd2,
    ST_TRUNC = 2'd3
  } status_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       header_start;
    logic       end_of_stream;
  } item_t;

  typedef struct packed {
    status_t     status;
    logic [15:0] channel_count;
    logic        sample_format;
    logic [31:0] sample_rate;
    logic [15:0] bits_per_sample;
  } result_t;

  typedef struct packed {
    logic       check;
    logic [7:0] want;
  } fixed_t;

  function automatic fixed_t fixed_byte(input logic [POS_W-1:0] pos);
    fixed_t f;
    f.check = 1'b1;
    f.want  = 8'h00;
    case (pos)
      POS_W'(0):  f.want = 8'h52;
      POS_W'(1):  f.want = 8'h49;
      POS_W'(2):  f.want = 8'h46;
      POS_W'(3):  f.want = 8'h46;
      POS_W'(8):  f.want = 8'h57;
      POS_W'(9):  f.want = 8'h41;
      POS_W'(10): f.want = 8'h56;
      POS_W'(11): f.want = 8'h45;
      POS_W'(12): f.want = 8'h66;
      POS_W'(13): f.want = 8'h6D;
      POS_W'(14): f.want = 8'h74;
      POS_W'(15): f.want = 8'h20;
      POS_W'(20): f.want = 8'h01;
      POS_W'(21): f.want = 8'h00;
      POS_W'(36): f.want = 8'h64;
      POS_W'(37): f.want = 8'h61;
      POS_W'(38): f.want = 8'h74;
      POS_W'(39): f.want = 8'h61;
      default:    f.check = 1'b0;
    endcase
    return f;
  endfunction

endpackage

[hdl/wpp_in_stage.sv]
// Input register of the WAV header parser.
// Depends on wpp_pkg and the assertion macros header.
`include "wav_pcm_header_parser_unit_macros.svh"

module wpp_in_stage import wpp_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_stall,
  input  item_t in_item,
  input  logic  space_ok,
  output logic  step,
  output item_t item
);

  logic  valid_r, valid_nxt;
  item_t item_r, item_nxt;
  logic  take;

  assign in_stall  = valid_r && !space_ok;
  assign take      = in_valid && !in_stall;
  assign step      = valid_r && space_ok;
  assign valid_nxt = take || (valid_r && !space_ok);
  assign item_nxt  = take ? in_item : item_r;
  assign item      = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    item_r <= item_nxt;
  end

  `WPP_ASSERT_NEXT(a_held_item_stays, clk, rst_n, valid_r && !space_ok, valid_r && $stable(item_r))

endmodule

[hdl/wpp_parser.sv]
// Header position tracking, tag checks and field capture.
// Depends on wpp_pkg and the assertion macros header.
`include "wav_pcm_header_parser_unit_macros.svh"

module wpp_parser import wpp_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    step,
  input  item_t   item,
  output logic    res_valid,
  output result_t res
);

  logic [POS_W-1:0] pos_r, pos_nxt, pos_eff;
  logic             tags_r, tags_nxt, tags_eff;
  logic [15:0]      chan_r, chan_nxt, chan_eff;
  logic [31:0]      rate_r, rate_nxt, rate_eff;
  logic [15:0]      bits_r, bits_nxt, bits_eff;
  fixed_t           fb;

  always_comb begin
    pos_nxt  = pos_r;
    tags_nxt = tags_r;
    chan_nxt = chan_r;
    rate_nxt = rate_r;
    bits_nxt = bits_r;
    pos_eff  = pos_r;
    tags_eff = tags_r;
    chan_eff = chan_r;
    rate_eff = rate_r;
    bits_eff = bits_r;
    fb       = fixed_byte(pos_r);
    res_valid = 1'b0;
    res.status          = ST_TRUNC;
    res.channel_count   = chan_r;
    res.sample_format   = 1'b0;
    res.sample_rate     = rate_r;
    res.bits_per_sample = bits_r;
    if (step) begin
      if (item.end_of_stream) begin
        if (pos_r < POS_IDLE) begin
          pos_nxt   = POS_IDLE;
          res_valid = 1'b1;
        end
      end else begin
        if (item.header_start) begin
          pos_eff  = '0;
          tags_eff = 1'b1;
          chan_eff = '0;
          rate_eff = '0;
          bits_eff = '0;
        end
        if (pos_eff < POS_IDLE) begin
          fb = fixed_byte(pos_eff);
          if (fb.check && (fb.want != item.data_byte)) begin
            tags_eff = 1'b0;
          end
          case (pos_eff)
            POS_W'(22): chan_eff[7:0]   = item.data_byte;
            POS_W'(23): chan_eff[15:8]  = item.data_byte;
            POS_W'(24): rate_eff[7:0]   = item.data_byte;
            POS_W'(25): rate_eff[15:8]  = item.data_byte;
            POS_W'(26): rate_eff[23:16] = item.data_byte;
            POS_W'(27): rate_eff[31:24] = item.data_byte;
            POS_W'(34): bits_eff[7:0]   = item.data_byte;
            POS_W'(35): bits_eff[15:8]  = item.data_byte;
            default: ;
          endcase
          pos_eff = pos_eff + POS_W'(1);
          if (pos_eff == POS_IDLE) begin
            res_valid = 1'b1;
            if (!tags_eff) begin
              res.status = ST_BAD;
            end else if (bits_eff == BITS_8) begin
              res.status = ST_OK;
            end else if (bits_eff == BITS_16) begin
              res.status        = ST_OK;
              res.sample_format = 1'b1;
            end else begin
              res.status = ST_SIZE;
            end
          end
        end
        pos_nxt  = pos_eff;
        tags_nxt = tags_eff;
        chan_nxt = chan_eff;
        rate_nxt = rate_eff;
        bits_nxt = bits_eff;
        res.channel_count   = chan_eff;
        res.sample_rate     = rate_eff;
        res.bits_per_sample = bits_eff;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= POS_IDLE;
      tags_r <= 1'b1;
      chan_r <= '0;
      rate_r <= '0;
      bits_r <= '0;
    end else begin
      pos_r  <= pos_nxt;
      tags_r <= tags_nxt;
      chan_r <= chan_nxt;
      rate_r <= rate_nxt;
      bits_r <= bits_nxt;
    end
  end

  `WPP_ASSERT_NOW(a_pos_in_range, clk, rst_n, 1'b1, pos_r <= POS_IDLE)
  `WPP_ASSERT_NEXT(a_idle_after_result, clk, rst_n, res_valid, pos_r == POS_IDLE)
  `WPP_ASSERT_NEXT(a_idle_after_eos, clk, rst_n, step && item.end_of_stream, pos_r == POS_IDLE)

endmodule

[hdl/wpp_out_reg.sv]
// Result register of the WAV header parser.
// Depends on wpp_pkg and the assertion macros header.
`include "wav_pcm_header_parser_unit_macros.svh"

module wpp_out_reg import wpp_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    res_valid,
  input  result_t res,
  output logic    space_ok,
  output logic    out_valid,
  input  logic    out_stall,
  output result_t out_res
);

  logic    valid_r, valid_nxt;
  result_t res_r, res_nxt;

  assign space_ok  = !valid_r || !out_stall;
  assign valid_nxt = res_valid || (valid_r && out_stall);
  assign res_nxt   = res_valid ? res : res_r;
  assign out_valid = valid_r;
  assign out_res   = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    res_r <= res_nxt;
  end

  `WPP_ASSERT_NOW(a_no_overwrite, clk, rst_n, valid_r && out_stall, !res_valid)

endmodule

[hdl/wav_pcm_header_parser_unit.sv]
// Top level of the WAV PCM header parser: input register, parser, result register.
// Depends on wpp_pkg, wpp_in_stage, wpp_parser and wpp_out_reg.
//
//   channel | direction | handshake           | payload
//   in_     | input     | in_valid / in_stall | data_byte, header_start, end_of_stream
//   out_    | output    | out_valid/out_stall | status, channel_count, sample_format,
//           |           |                     | sample_rate, bits_per_sample
//
// One byte per cycle unless in_stall is high: the input register takes the transfer,
// the parser decodes it, and the result register captures its result for out_valid.
// Reset (rst_n low, synchronous) leaves the parser idle, waiting for header_start.
// A stalled result holds the result register; the input register then holds one
// more byte and in_stall rises until the result transfer happens.
module wav_pcm_header_parser_unit import wpp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_header_start,
  input  logic        in_end_of_stream,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic [15:0] out_channel_count,
  output logic        out_sample_format,
  output logic [31:0] out_sample_rate,
  output logic [15:0] out_bits_per_sample
);

  item_t   in_item, item;
  logic    space_ok, step, res_valid;
  result_t res, out_res;

  assign in_item.data_byte     = in_data_byte;
  assign in_item.header_start  = in_header_start;
  assign in_item.end_of_stream = in_end_of_stream;

  wpp_in_stage u_in_stage (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .space_ok (space_ok),
    .step     (step),
    .item     (item)
  );

  wpp_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .item      (item),
    .res_valid (res_valid),
    .res       (res)
  );

  wpp_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res       (res),
    .space_ok  (space_ok),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

  assign out_status          = out_res.status;
  assign out_channel_count   = out_res.channel_count;
  assign out_sample_format   = out_res.sample_format;
  assign out_sample_rate     = out_res.sample_rate;
  assign out_bits_per_sample = out_res.bits_per_sample;

endmodule

[tb/wav_pcm_header_parser_unit_tb.sv]
// Self-checking testbench for wav_pcm_header_parser_unit: streams WAV header bytes,
// predicts each header report and checks every result transfer field by field.
// Depends on wpp_pkg and the RTL under hdl/.
`timescale 1ns / 1ps

module wav_pcm_header_parser_unit_tb;
  import wpp_pkg::*;

  localparam int CYCLE_LIMIT = 200_000;
  localparam int STREAM_BYTES = 1950;
  localparam logic [31:0] TAG_RIFF = "RIFF";
  localparam logic [31:0] TAG_WAVE = "WAVE";
  localparam logic [31:0] TAG_FMT  = "fmt ";
  localparam logic [31:0] TAG_DATA = "data";
  localparam logic [15:0] FORMAT_LINEAR = 16'd1;

  typedef struct {
    item_t it;
    bit    drain;
  } feed_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_data_byte = 8'h00;
  logic        in_header_start = 1'b0;
  logic        in_end_of_stream = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  out_status;
  logic [15:0] out_channel_count;
  logic        out_sample_format;
  logic [31:0] out_sample_rate;
  logic [15:0] out_bits_per_sample;

  feed_t   byte_feed [$];
  result_t reports_due [$];
  feed_t   head;
  item_t   cur_item;
  result_t want_rep;
  bit      slot_full = 1'b0;
  int      cyc = 0;
  int      err_count = 0;

  // parser state mirror
  logic [POS_W-1:0] hdr_pos = POS_IDLE;
  logic             tags_ok = 1'b1;
  logic [15:0]      seen_channels = '0;
  logic [31:0]      seen_rate = '0;
  logic [15:0]      seen_bits = '0;

  wav_pcm_header_parser_unit u_top (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_data_byte        (in_data_byte),
    .in_header_start     (in_header_start),
    .in_end_of_stream    (in_end_of_stream),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_status          (out_status),
    .out_channel_count   (out_channel_count),
    .out_sample_format   (out_sample_format),
    .out_sample_rate     (out_sample_rate),
    .out_bits_per_sample (out_bits_per_sample)
  );

  always #1 clk = ~clk;

  function automatic bit layout_byte(input int pos, output logic [7:0] want);
    want = 8'h00;
    if (pos <= 3) want = TAG_RIFF[31 - 8*pos -: 8];
    else if (pos >= 8 && pos <= 11) want = TAG_WAVE[31 - 8*(pos - 8) -: 8];
    else if (pos >= 12 && pos <= 15) want = TAG_FMT[31 - 8*(pos - 12) -: 8];
    else if (pos == 20) want = FORMAT_LINEAR[7:0];
    else if (pos == 21) want = FORMAT_LINEAR[15:8];
    else if (pos >= 36 && pos <= 39) want = TAG_DATA[31 - 8*(pos - 36) -: 8];
    else return 1'b0;
    return 1'b1;
  endfunction

  function automatic result_t make_report(input status_t st, input logic fmt);
    result_t r;
    r.status          = st;
    r.channel_count   = seen_channels;
    r.sample_format   = fmt;
    r.sample_rate     = seen_rate;
    r.bits_per_sample = seen_bits;
    return r;
  endfunction

  task automatic parse_byte(input item_t it);
    logic [7:0] want;
    if (it.end_of_stream) begin
      if (hdr_pos < POS_IDLE) begin
        hdr_pos = POS_IDLE;
        reports_due.push_back(make_report(ST_TRUNC, 1'b0));
      end
      return;
    end
    if (it.header_start) begin
      hdr_pos       = '0;
      tags_ok       = 1'b1;
      seen_channels = '0;
      seen_rate     = '0;
      seen_bits     = '0;
    end
    if (hdr_pos >= POS_IDLE) return;
    if (layout_byte(int'(hdr_pos), want) && it.data_byte != want) tags_ok = 1'b0;
    case (int'(hdr_pos))
      22: seen_channels[7:0]  = it.data_byte;
      23: seen_channels[15:8] = it.data_byte;
      24: seen_rate[7:0]      = it.data_byte;
      25: seen_rate[15:8]     = it.data_byte;
      26: seen_rate[23:16]    = it.data_byte;
      27: seen_rate[31:24]    = it.data_byte;
      34: seen_bits[7:0]      = it.data_byte;
      35: seen_bits[15:8]     = it.data_byte;
      default: ;
    endcase
    hdr_pos = hdr_pos + POS_W'(1);
    if (hdr_pos != POS_IDLE) return;
    if (!tags_ok) reports_due.push_back(make_report(ST_BAD, 1'b0));
    else if (seen_bits == BITS_8) reports_due.push_back(make_report(ST_OK, 1'b0));
    else if (seen_bits == BITS_16) reports_due.push_back(make_report(ST_OK, 1'b1));
    else reports_due.push_back(make_report(ST_SIZE, 1'b0));
  endtask

  task automatic queue_byte(input logic [7:0] d, input logic s, input logic e, input bit drain);
    feed_t f;
    f.it.data_byte     = d;
    f.it.header_start  = s;
    f.it.end_of_stream = e;
    f.drain            = drain;
    byte_feed.push_back(f);
  endtask

  // quiet stretch with no idling on either side
  function automatic bit idle_now();
    if (cyc >= 500 && cyc < 1500) return 1'b0;
    return $urandom_range(99) < 6;
  endfunction

  always @(negedge clk) begin
    out_stall <= idle_now();
  end

  always @(negedge clk) begin
    if (rst_n && !slot_full) begin
      if (byte_feed.size() != 0 && !idle_now() &&
          !(byte_feed[0].drain && reports_due.size() != 0)) begin
        head = byte_feed.pop_front();
        cur_item = head.it;
        in_data_byte     <= head.it.data_byte;
        in_header_start  <= head.it.header_start;
        in_end_of_stream <= head.it.end_of_stream;
        in_valid         <= 1'b1;
        slot_full = 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc == CYCLE_LIMIT) begin
      $display("wav_pcm_header_parser_unit_tb NOT OK");
      $finish;
    end else if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (reports_due.size() == 0) begin
          $error("result transfer with no report expected");
          err_count++;
        end else begin
          want_rep = reports_due.pop_front();
          if (out_status !== want_rep.status) begin
            $error("status: expected %0d, got %0d", want_rep.status, out_status);
            err_count++;
          end
          if (out_channel_count !== want_rep.channel_count) begin
            $error("channel_count: expected %0d, got %0d",
                   want_rep.channel_count, out_channel_count);
            err_count++;
          end
          if (out_sample_format !== want_rep.sample_format) begin
            $error("sample_format: expected %0d, got %0d",
                   want_rep.sample_format, out_sample_format);
            err_count++;
          end
          if (out_sample_rate !== want_rep.sample_rate) begin
            $error("sample_rate: expected %0d, got %0d",
                   want_rep.sample_rate, out_sample_rate);
            err_count++;
          end
          if (out_bits_per_sample !== want_rep.bits_per_sample) begin
            $error("bits_per_sample: expected %0d, got %0d",
                   want_rep.bits_per_sample, out_bits_per_sample);
            err_count++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        parse_byte(cur_item);
        slot_full = 1'b0;
      end
    end
  end

  initial begin
    logic [7:0]  hdr [HDR_BYTES];
    logic [7:0]  b;
    logic [15:0] ch, bits;
    logic [31:0] rate;
    int n_bytes, n_headers, len, r, k, p;

    // directed: idle traffic, end of stream, restart, truncation
    queue_byte(8'h00, 1'b0, 1'b0, 1'b0);
    queue_byte(8'hFF, 1'b0, 1'b0, 1'b0);
    queue_byte(8'hA5, 1'b0, 1'b1, 1'b0);
    queue_byte(8'hFF, 1'b1, 1'b1, 1'b0);
    queue_byte(8'h52, 1'b1, 1'b0, 1'b0);
    queue_byte(8'h49, 1'b0, 1'b0, 1'b0);
    queue_byte(8'h00, 1'b0, 1'b1, 1'b0);
    queue_byte(8'hFF, 1'b1, 1'b0, 1'b0);
    queue_byte(8'h00, 1'b0, 1'b0, 1'b0);
    queue_byte(8'h52, 1'b1, 1'b0, 1'b0);
    queue_byte(8'h5A, 1'b1, 1'b1, 1'b0);
    queue_byte(8'hFF, 1'b0, 1'b0, 1'b0);
    queue_byte(8'h00, 1'b1, 1'b0, 1'b0);
    queue_byte(8'hFF, 1'b0, 1'b1, 1'b0);

    n_bytes   = 0;
    n_headers = 0;
    while (n_bytes < STREAM_BYTES) begin
      for (int i = 0; i < HDR_BYTES; i++) begin
        if (!layout_byte(i, b)) b = 8'($urandom_range(255));
        hdr[i] = b;
      end
      k = $urandom_range(9);
      if (k <= 5) ch = 16'($urandom_range(1, 2));
      else if (k == 6) ch = 16'h0000;
      else if (k == 7) ch = 16'hFFFF;
      else ch = 16'($urandom_range(16'hFFFF));
      k = $urandom_range(9);
      case (k)
        0: rate = 32'd8000;
        1: rate = 32'd11025;
        2: rate = 32'd22050;
        3: rate = 32'd44100;
        4: rate = 32'd48000;
        5: rate = 32'd96000;
        6: rate = 32'h0000_0000;
        7: rate = 32'hFFFF_FFFF;
        default: rate = $urandom;
      endcase
      k = $urandom_range(11);
      case (k)
        0, 1, 2, 3: bits = BITS_8;
        4, 5, 6, 7: bits = BITS_16;
        8: bits = 16'hFFFF;
        9: bits = 16'h0000;
        10: bits = BITS_16 | 16'h0100;
        default: bits = 16'($urandom_range(16'hFFFF));
      endcase
      {hdr[23], hdr[22]} = ch;
      {hdr[27], hdr[26], hdr[25], hdr[24]} = rate;
      {hdr[35], hdr[34]} = bits;
      if ($urandom_range(99) < 15) begin
        for (int c = 0; c <= int'($urandom_range(1)); c++) begin
          k = $urandom_range(17);
          if (k < 4) p = k;
          else if (k < 12) p = k + 4;
          else if (k < 14) p = k + 8;
          else p = k + 22;
          hdr[p] = hdr[p] ^ 8'($urandom_range(1, 255));
        end
      end

      r = $urandom_range(99);
      len = (r < 72) ? HDR_BYTES : $urandom_range(1, HDR_BYTES - 1);
      for (int i = 0; i < len; i++)
        queue_byte(hdr[i], i == 0, 1'b0, i == 0 && n_headers % 12 == 0);
      n_bytes += len;
      n_headers++;
      if (r >= 72 && r < 86) begin
        queue_byte(8'($urandom_range(255)), 1'($urandom_range(1)), 1'b1, 1'b0);
      end else if (r < 72) begin
        for (int i = 0; i < int'($urandom_range(3)); i++)
          queue_byte(8'($urandom_range(255)), 1'b0, $urandom_range(99) < 20, 1'b0);
      end
    end

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (byte_feed.size() != 0 || slot_full || reports_due.size() != 0)
      @(posedge clk);
    repeat (8) @(posedge clk);
    if (err_count == 0 && reports_due.size() == 0)
      $display("wav_pcm_header_parser_unit_tb OK");
    else
      $display("wav_pcm_header_parser_unit_tb NOT OK");
    $finish;
  end

endmodule

[sim.f]
+incdir+hdl
hdl/wpp_pkg.sv
hdl/wpp_in_stage.sv
hdl/wpp_parser.sv
hdl/wpp_out_reg.sv
hdl/wav_pcm_header_parser_unit.sv
tb/wav_pcm_header_parser_unit_tb.sv
